// ===== design/wpg_pkg.sv =====
// Package for the windowed PD growth controller.
// Holds shared types, register indexes and the saturation helper; no dependencies.
package wpg_pkg;

  localparam int unsigned WinLen = 64;
  localparam logic [31:0] StepRateReset = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_SET_POINT = 3'd0,
    REG_P_COEF    = 3'd1,
    REG_D_COEF    = 3'd2,
    REG_OUT_LIMIT = 3'd3,
    REG_STEP_RATE = 3'd4
  } wpg_reg_e;

  typedef struct packed {
    logic signed [31:0] err;
    logic               active;
  } wpg_item_t;

  typedef struct packed {
    logic signed [31:0] p_coef;
    logic signed [31:0] d_coef;
    logic signed [31:0] out_limit;
    logic        [31:0] step_rate;
  } wpg_cfg_t;

  typedef struct packed {
    logic signed [31:0] prop_signal;
    logic signed [31:0] deriv_signal;
    logic signed [31:0] prop_output;
    logic signed [31:0] deriv_output;
    logic signed [31:0] drive;
    logic               window_valid;
  } wpg_res_t;

  // Applies a sign to a magnitude and saturates to 32 signed bits.
  function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(-mag[31:0]);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = mag[31:0];
      end
    end
    return $signed(r);
  endfunction

endpackage

// ===== design/wpg_div.sv =====
// Restoring unsigned divider producing one quotient bit per cycle.
// Standalone; used by the front part of the controller.
module wpg_div #(
  parameter int unsigned DW = 49,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/wpg_front.sv =====
// Front part: accepts a measured sample and forms the relative error.
// Depends on wpg_pkg and wpg_div.
module wpg_front
  import wpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic signed [31:0] signal_i,
  input  logic               growth_active_i,
  output logic               full_o,
  input  logic signed [31:0] set_point_i,
  input  logic               fifo_full_i,
  output logic               fifo_push_o,
  output wpg_item_t          item_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } state_e;

  state_e             state_q;
  logic               div_start_q;
  logic [48:0]        dividend_q;
  logic [31:0]        divisor_q;
  logic               neg_q;
  wpg_item_t          item_q;
  logic               div_done;
  logic [48:0]        div_quo;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic [31:0]        sp_abs;

  always_comb begin
    diff     = {signal_i[31], signal_i} - {set_point_i[31], set_point_i};
    diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    sp_abs   = set_point_i[31] ? 32'(-set_point_i) : 32'(set_point_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      div_start_q <= 1'b0;
      dividend_q  <= '0;
      divisor_q   <= '0;
      neg_q       <= 1'b0;
      item_q      <= '0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            item_q.active <= growth_active_i;
            if (set_point_i == 32'sd0) begin
              item_q.err <= signal_i;
              state_q    <= F_PUSH;
            end else begin
              dividend_q  <= {diff_abs, 16'h0000};
              divisor_q   <= sp_abs;
              neg_q       <= diff[32] ^ set_point_i[31];
              div_start_q <= 1'b1;
              state_q     <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (div_done) begin
            item_q.err <= sat_mag(64'(div_quo), neg_q);
            state_q    <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!fifo_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  wpg_div #(.DW(49), .VW(32)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dividend_q),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign full_o      = (state_q != F_IDLE);
  assign fifo_push_o = (state_q == F_PUSH) && !fifo_full_i;
  assign item_o      = item_q;

endmodule

// ===== design/wpg_fifo.sv =====
// Two-entry queue carrying error items from the front part to the back part.
// Depends on wpg_pkg.
module wpg_fifo
  import wpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wpg_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output wpg_item_t item_o,
  output logic      empty_o
);

  wpg_item_t   entry_q [2];
  logic        wp_q;
  logic        rp_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = entry_q[rp_q];

endmodule

// ===== design/wpg_back.sv =====
// Back part: sliding window, running sums, mean, slope, gains and clamp.
// Depends on wpg_pkg; holds the window memory and the result register.
module wpg_back
  import wpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  wpg_item_t item_i,
  output logic      item_pop_o,
  input  wpg_cfg_t  cfg_i,
  output logic      res_valid_o,
  output wpg_res_t  res_o,
  input  logic      res_pop_i
);

  localparam int unsigned CW      = $clog2(WinLen + 1);
  localparam int unsigned AW      = $clog2(WinLen);
  localparam int unsigned WinLog2 = $clog2(WinLen);
  localparam int unsigned SUMW    = 32 + $clog2(WinLen) + 1;
  localparam longint      NL      = longint'(WinLen);
  localparam longint      SXL     = (NL * (NL - 1)) / 2;
  localparam logic signed [63:0] NN  = 64'(NL);
  localparam logic signed [63:0] NM1 = 64'(NL - 1);
  localparam logic signed [63:0] SX  = 64'(SXL);
  // For a 64-entry window the slope divisor 1397760 is 2^10 * 4095 / 3, so
  // |num| * 65536 / 1397760 equals |num| * 192 / 4095.
  localparam logic [55:0] SlopeDiv = 56'd4095;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_MEAN,
    B_NUM1,
    B_NUM2,
    B_NUM3,
    B_RECIP,
    B_FIX,
    B_MULR,
    B_GP,
    B_MULP,
    B_GD,
    B_MULD,
    B_DRV,
    B_OUT
  } state_e;

  logic signed [31:0] mem [WinLen];
  logic signed [31:0] rdata_q;

  state_e                 state_q;
  logic [AW-1:0]          wptr_q;
  logic [CW-1:0]          fill_q;
  logic signed [SUMW-1:0] sum_q;
  logic signed [63:0]     wsum_q;
  logic signed [31:0]     e_q;
  logic                   act_q;
  logic                   neg_q;
  logic signed [63:0]     pa_q;
  logic signed [63:0]     pb_q;
  logic signed [63:0]     num_q;
  logic [55:0]            z_q;
  logic [55:0]            part_q;
  logic [55:0]            qacc_q;
  logic [55:0]            rem_q;
  logic [95:0]            ma_q;
  logic [31:0]            mb_q;
  logic [95:0]            acc_q;
  logic [5:0]             mcnt_q;
  logic signed [31:0]     ps_q;
  logic signed [31:0]     ds_q;
  logic signed [31:0]     po_q;
  logic signed [31:0]     do_q;
  logic signed [31:0]     drv_q;
  logic                   out_valid_q;
  wpg_res_t               res_q;

  logic                   mem_we;
  logic signed [31:0]     old;
  logic signed [SUMW-1:0] old_ext;
  logic signed [SUMW-1:0] e_ext;
  logic signed [SUMW-1:0] rest;
  logic signed [SUMW-1:0] s_new;
  logic [SUMW-1:0]        s_abs;
  logic signed [63:0]     e64;
  logic signed [63:0]     w_new;
  logic [CW-1:0]          fill_new;
  logic [63:0]            num_abs;
  logic [55:0]            z_new;
  logic [55:0]            rem_new;
  logic [31:0]            ps_abs;
  logic [31:0]            ds_abs;
  logic [31:0]            pg_abs;
  logic [31:0]            dg_abs;
  logic signed [32:0]     dsum;
  logic signed [32:0]     lim;

  always_comb begin
    old      = (fill_q == CW'(WinLen)) ? rdata_q : 32'sd0;
    old_ext  = {{(SUMW-32){old[31]}}, old};
    e_ext    = {{(SUMW-32){e_q[31]}}, e_q};
    rest     = sum_q - old_ext;
    s_new    = rest + e_ext;
    s_abs    = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
    e64      = {{32{e_q[31]}}, e_q};
    w_new    = wsum_q - {{(64-SUMW){rest[SUMW-1]}}, rest} + 64'(e64 * NM1);
    fill_new = (fill_q == CW'(WinLen)) ? fill_q : fill_q + 1'b1;
    num_abs  = num_q[63] ? 64'(-num_q) : 64'(num_q);
    z_new    = 56'(num_abs << 7) + 56'(num_abs << 6);
    rem_new  = z_q - ((qacc_q << 12) - qacc_q);
    ps_abs   = ps_q[31] ? 32'(-ps_q) : 32'(ps_q);
    ds_abs   = ds_q[31] ? 32'(-ds_q) : 32'(ds_q);
    pg_abs   = cfg_i.p_coef[31] ? 32'(-cfg_i.p_coef) : 32'(cfg_i.p_coef);
    dg_abs   = cfg_i.d_coef[31] ? 32'(-cfg_i.d_coef) : 32'(cfg_i.d_coef);
    dsum     = {po_q[31], po_q} + {do_q[31], do_q};
    lim      = cfg_i.out_limit[31] ? 33'sd0 : {1'b0, cfg_i.out_limit};
    mem_we   = (state_q == B_READ);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wptr_q] <= e_q;
    end
    rdata_q <= mem[wptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wptr_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      wsum_q      <= '0;
      e_q         <= '0;
      act_q       <= 1'b0;
      neg_q       <= 1'b0;
      pa_q        <= '0;
      pb_q        <= '0;
      num_q       <= '0;
      z_q         <= '0;
      part_q      <= '0;
      qacc_q      <= '0;
      rem_q       <= '0;
      ma_q        <= '0;
      mb_q        <= '0;
      acc_q       <= '0;
      mcnt_q      <= '0;
      ps_q        <= '0;
      ds_q        <= '0;
      po_q        <= '0;
      do_q        <= '0;
      drv_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (mcnt_q != 6'd0) begin
        acc_q  <= acc_q + (mb_q[0] ? ma_q : 96'd0);
        ma_q   <= {ma_q[94:0], 1'b0};
        mb_q   <= {1'b0, mb_q[31:1]};
        mcnt_q <= mcnt_q - 1'b1;
      end
      case (state_q)
        B_IDLE: begin
          if (item_valid_i) begin
            e_q     <= item_i.err;
            act_q   <= item_i.active;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          sum_q  <= s_new;
          wsum_q <= w_new;
          fill_q <= fill_new;
          wptr_q <= (wptr_q == AW'(WinLen - 1)) ? '0 : wptr_q + 1'b1;
          if (fill_new != CW'(WinLen)) begin
            ps_q  <= '0;
            ds_q  <= '0;
            po_q  <= '0;
            do_q  <= '0;
            drv_q <= '0;
            state_q <= B_OUT;
          end else begin
            state_q <= B_MEAN;
          end
        end
        B_MEAN: begin
          ps_q    <= sat_mag(64'(s_abs >> WinLog2), sum_q[SUMW-1]);
          state_q <= B_NUM1;
        end
        B_NUM1: begin
          pa_q    <= 64'(NN * wsum_q);
          pb_q    <= 64'(SX * {{(64-SUMW){sum_q[SUMW-1]}}, sum_q});
          state_q <= B_NUM2;
        end
        B_NUM2: begin
          num_q   <= pa_q - pb_q;
          state_q <= B_NUM3;
        end
        B_NUM3: begin
          z_q     <= z_new;
          part_q  <= z_new >> 12;
          qacc_q  <= '0;
          neg_q   <= num_q[63];
          state_q <= B_RECIP;
        end
        B_RECIP: begin
          // The quotient by 4095 is the sum of the base-4096 shifts, short by a few units.
          if (part_q != '0) begin
            qacc_q <= qacc_q + part_q;
            part_q <= part_q >> 12;
          end else begin
            rem_q   <= rem_new;
            state_q <= B_FIX;
          end
        end
        B_FIX: begin
          if (rem_q >= SlopeDiv) begin
            rem_q  <= rem_q - SlopeDiv;
            qacc_q <= qacc_q + 1'b1;
          end else begin
            ma_q    <= 96'(qacc_q);
            mb_q    <= cfg_i.step_rate;
            acc_q   <= '0;
            mcnt_q  <= 6'd32;
            state_q <= B_MULR;
          end
        end
        B_MULR: begin
          if (mcnt_q == 6'd0) begin
            ds_q    <= sat_mag(acc_q[95:32], neg_q);
            state_q <= B_GP;
          end
        end
        B_GP: begin
          if (!act_q) begin
            po_q    <= '0;
            do_q    <= '0;
            state_q <= B_DRV;
          end else begin
            ma_q    <= 96'(pg_abs);
            mb_q    <= ps_abs;
            acc_q   <= '0;
            mcnt_q  <= 6'd32;
            state_q <= B_MULP;
          end
        end
        B_MULP: begin
          if (mcnt_q == 6'd0) begin
            po_q    <= sat_mag(acc_q[79:16], cfg_i.p_coef[31] ^ ps_q[31]);
            state_q <= B_GD;
          end
        end
        B_GD: begin
          ma_q    <= 96'(dg_abs);
          mb_q    <= ds_abs;
          acc_q   <= '0;
          mcnt_q  <= 6'd32;
          state_q <= B_MULD;
        end
        B_MULD: begin
          if (mcnt_q == 6'd0) begin
            do_q    <= sat_mag(acc_q[79:16], cfg_i.d_coef[31] ^ ds_q[31]);
            state_q <= B_DRV;
          end
        end
        B_DRV: begin
          if (!dsum[32]) begin
            drv_q <= (dsum > lim) ? 32'(lim) : 32'(dsum);
          end else begin
            drv_q <= (dsum < -lim) ? 32'(-lim) : 32'(dsum);
          end
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_q) begin
            res_q.prop_signal  <= ps_q;
            res_q.deriv_signal <= ds_q;
            res_q.prop_output  <= po_q;
            res_q.deriv_output <= do_q;
            res_q.drive        <= drv_q;
            res_q.window_valid <= (fill_q == CW'(WinLen));
            out_valid_q        <= 1'b1;
            state_q            <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign item_pop_o  = (state_q == B_IDLE) && item_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WinLen))
    else $error("fill count exceeds window");

  a_partial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.window_valid |-> res_q.drive == 32'sd0 &&
      res_q.prop_signal == 32'sd0 && res_q.deriv_signal == 32'sd0)
    else $error("partial window result is not zero");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.window_valid |-> fill_q == CW'(WinLen))
    else $error("valid result without a full window");
`endif

endmodule

// ===== design/windowed_pd_growth_controller.sv =====
// Windowed PD growth controller: the front runs a serial 49-bit divide per item with a nonzero
// set point and skips it with a zero one; the back runs three 32-step shift-add multiplies
// with a full window and growth active, only the slope multiply with growth inactive and
// none while the window fills, plus any wait for the previous result to be taken. Each part
// takes a new item only once it has passed on the last. Reset clears control state and most
// registers; divider datapath and window memory are not reset; a fill count masks old memory.
module windowed_pd_growth_controller
  import wpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] signal_i,
  input  logic               growth_active_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] prop_signal_o,
  output logic signed [31:0] deriv_signal_o,
  output logic signed [31:0] prop_output_o,
  output logic signed [31:0] deriv_output_o,
  output logic signed [31:0] drive_o,
  output logic               window_valid_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic signed [31:0] set_point_q;
  wpg_cfg_t           cfg_q;
  logic               fifo_push;
  logic               fifo_full;
  logic               fifo_empty;
  logic               fifo_pop;
  wpg_item_t          front_item;
  wpg_item_t          fifo_item;
  logic               res_valid;
  wpg_res_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_point_q     <= '0;
      cfg_q.p_coef    <= '0;
      cfg_q.d_coef    <= '0;
      cfg_q.out_limit <= '0;
      cfg_q.step_rate <= StepRateReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SET_POINT: set_point_q     <= $signed(cfg_data_i);
        REG_P_COEF:    cfg_q.p_coef    <= $signed(cfg_data_i);
        REG_D_COEF:    cfg_q.d_coef    <= $signed(cfg_data_i);
        REG_OUT_LIMIT: cfg_q.out_limit <= $signed(cfg_data_i);
        REG_STEP_RATE: cfg_q.step_rate <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wpg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .signal_i        (signal_i),
    .growth_active_i (growth_active_i),
    .full_o          (full),
    .set_point_i     (set_point_q),
    .fifo_full_i     (fifo_full),
    .fifo_push_o     (fifo_push),
    .item_o          (front_item)
  );

  wpg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .item_o  (fifo_item),
    .empty_o (fifo_empty)
  );

  wpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!fifo_empty),
    .item_i       (fifo_item),
    .item_pop_o   (fifo_pop),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign cfg_ready_o    = 1'b1;
  assign empty          = !res_valid;
  assign prop_signal_o  = res.prop_signal;
  assign deriv_signal_o = res.deriv_signal;
  assign prop_output_o  = res.prop_output;
  assign deriv_output_o = res.deriv_output;
  assign drive_o        = res.drive;
  assign window_valid_o = res.window_valid;

endmodule
